// ----- rtl/core/tcw_pkg.sv -----
//------------------------------------------------------------------------------
// Text console character writer package
// Geometry constants, character codes, item and result types, and the
// command and status types shared by the controller and the datapath.
//------------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int TAB_STOP   = 8;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = $clog2(COLUMNS + TAB_STOP);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int TOP_W  = $clog2(ROWS);
    localparam int FILL_W = $clog2(COLUMNS);

    localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [7:0] CODE_RETURN    = 8'h0D;
    localparam logic [7:0] CODE_TAB       = 8'h09;
    localparam logic [7:0] CODE_BACKSPACE = 8'h08;
    localparam logic [7:0] CODE_SPACE     = 8'h20;
    localparam logic [7:0] DEFAULT_ATTR   = 8'h07;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
        logic [7:0] char_color;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } item_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
        logic       scrolled;
    } result_t;

    typedef enum logic [2:0] {
        KIND_NEWLINE,
        KIND_RETURN,
        KIND_TAB,
        KIND_BACK,
        KIND_PRINT
    } char_kind_t;

    typedef enum logic [3:0] {
        CUR_HOLD,
        CUR_NEWLINE,
        CUR_RETURN,
        CUR_TAB,
        CUR_BACK,
        CUR_ADVANCE,
        CUR_WRAP,
        CUR_SCROLL,
        CUR_HOME
    } cur_op_t;

    typedef enum logic [2:0] {
        ADR_HOLD,
        ADR_CURSOR,
        ADR_READ,
        ADR_BOTTOM,
        ADR_ZERO,
        ADR_INC
    } adr_op_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_READ,
        MEM_WR_CHAR,
        MEM_WR_BACK,
        MEM_WR_BLANK,
        MEM_WR_DEFAULT
    } mem_op_t;

    typedef struct packed {
        logic    load_item;
        cur_op_t cur_op;
        adr_op_t adr_op;
        mem_op_t mem_op;
        logic    fill_clr;
        logic    scroll_set;
        logic    finish;
    } dp_ctrl_t;

    typedef struct packed {
        logic [1:0] command;
        char_kind_t kind;
        logic       col_zero;
        logic       row_over;
        logic       read_ok;
        logic       fill_last;
        logic       clear_last;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_ADDR,
        ST_READ,
        ST_BACK_WR,
        ST_CHAR_WR,
        ST_WRAP,
        ST_SCROLL,
        ST_FILL_ADDR,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/text_console_char_writer.sv -----
//------------------------------------------------------------------------------
// Text console character writer
// Teletype-style 80 by 25 character console with cursor, wrap and scroll.
//------------------------------------------------------------------------------
// A command is transferred when start is high and busy is low; exactly one
// result follows, shown for one cycle with done high, and the receiver cannot
// stall it. The cell store is a single-port memory, so cells are accessed one
// at a time. A printable character is written to its cell; a backspace that
// edits a cell reads it and writes it back with a blank character; a read
// outside the screen or an unused command touches no cell. A scroll moves no
// data (rows form a ring), but the new bottom row is blanked. Clear blanks
// every cell and homes the cursor. After reset the block stays busy while it
// blanks the store.
//------------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer
    import tcw_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire item_t item,
    output logic       done,
    output result_t    result
);

    dp_ctrl_t   ctrl;
    dp_status_t status;

    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .ctrl   (ctrl)
    );

    tcw_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .ctrl   (ctrl),
        .status (status),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

// ----- rtl/core/tcw_datapath.sv -----
//------------------------------------------------------------------------------
// Text console datapath
// Cell memory, cursor and scroll-origin registers, address generation and
// the result register.
//------------------------------------------------------------------------------
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire item_t      item,
    input  wire dp_ctrl_t   ctrl,
    output dp_status_t      status,
    output logic            done,
    output result_t         result
);

    localparam logic [COL_W-1:0] TAB_MASK = ~COL_W'(TAB_STOP - 1);

    logic [15:0]       mem [CELL_COUNT];
    logic [15:0]       rd_data_reg;
    logic              mem_we;
    logic [15:0]       mem_wdata;

    item_t             item_reg;
    logic [COL_W-1:0]  cur_col_reg,  cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg,  cur_row_next;
    logic [TOP_W-1:0]  top_reg,      top_next;
    logic [ADDR_W-1:0] addr_reg,     addr_next;
    logic [FILL_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic              scroll_reg,   scroll_next;
    logic              done_reg;
    result_t           result_reg;

    logic [TOP_W-1:0]  src_row;
    logic [ADDR_W-1:0] src_col;
    logic [TOP_W:0]    phys_sum;
    logic [TOP_W-1:0]  phys_row;
    logic [ADDR_W-1:0] cell_addr;
    logic [TOP_W-1:0]  top_inc;
    logic              col_over;
    logic              read_ok;

    assign col_over = cur_col_reg >= COL_W'(COLUMNS);
    assign read_ok  = (int'(item_reg.read_row) < ROWS) && (int'(item_reg.read_col) < COLUMNS);
    assign top_inc  = (top_reg == TOP_W'(ROWS - 1)) ? '0 : TOP_W'(top_reg + 1'b1);

    // The store is a ring of rows; top_reg names the physical row shown on top.
    always_comb
    begin
        case (ctrl.adr_op)
            ADR_READ:
            begin
                src_row = TOP_W'(item_reg.read_row);
                src_col = ADDR_W'(item_reg.read_col);
            end
            ADR_BOTTOM:
            begin
                src_row = TOP_W'(ROWS - 1);
                src_col = '0;
            end
            default:
            begin
                src_row = TOP_W'(cur_row_reg);
                src_col = ADDR_W'(cur_col_reg);
            end
        endcase
        phys_sum  = {1'b0, src_row} + {1'b0, top_reg};
        phys_row  = (phys_sum >= (TOP_W + 1)'(ROWS)) ? TOP_W'(phys_sum - (TOP_W + 1)'(ROWS))
                                                      : TOP_W'(phys_sum);
        cell_addr = ADDR_W'(ADDR_W'(phys_row) * ADDR_W'(COLUMNS)) + src_col;
    end

    always_comb
    begin
        case (ctrl.adr_op)
            ADR_CURSOR, ADR_READ, ADR_BOTTOM: addr_next = cell_addr;
            ADR_ZERO:                         addr_next = '0;
            ADR_INC:                          addr_next = ADDR_W'(addr_reg + 1'b1);
            default:                          addr_next = addr_reg;
        endcase
    end

    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        top_next     = top_reg;
        case (ctrl.cur_op)
            CUR_NEWLINE:
            begin
                cur_col_next = '0;
                cur_row_next = ROW_W'(cur_row_reg + 1'b1);
            end
            CUR_RETURN:  cur_col_next = '0;
            CUR_TAB:     cur_col_next = COL_W'(cur_col_reg + COL_W'(TAB_STOP)) & TAB_MASK;
            CUR_BACK:    cur_col_next = COL_W'(cur_col_reg - 1'b1);
            CUR_ADVANCE: cur_col_next = COL_W'(cur_col_reg + 1'b1);
            CUR_WRAP:
            begin
                if (col_over)
                begin
                    cur_col_next = '0;
                    cur_row_next = ROW_W'(cur_row_reg + 1'b1);
                end
            end
            CUR_SCROLL:
            begin
                cur_row_next = ROW_W'(ROWS - 1);
                top_next     = top_inc;
            end
            CUR_HOME:
            begin
                cur_col_next = '0;
                cur_row_next = '0;
                top_next     = '0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b1;
        mem_wdata = {DEFAULT_ATTR, CODE_SPACE};
        case (ctrl.mem_op)
            MEM_WR_CHAR:    mem_wdata = {item_reg.char_color, item_reg.char_code};
            MEM_WR_BACK:    mem_wdata = {rd_data_reg[15:8], CODE_SPACE};
            MEM_WR_BLANK:   mem_wdata = {item_reg.char_color, CODE_SPACE};
            MEM_WR_DEFAULT: mem_wdata = {DEFAULT_ATTR, CODE_SPACE};
            default:        mem_we    = 1'b0;
        endcase
    end

    always_comb
    begin
        fill_cnt_next = fill_cnt_reg;
        if (ctrl.fill_clr)
        begin
            fill_cnt_next = '0;
        end
        else if (ctrl.mem_op == MEM_WR_BLANK)
        begin
            fill_cnt_next = FILL_W'(fill_cnt_reg + 1'b1);
        end
        scroll_next = ctrl.load_item ? 1'b0 : (scroll_reg | ctrl.scroll_set);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        if (ctrl.mem_op == MEM_READ)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            item_reg <= item;
        end
        if (ctrl.finish)
        begin
            result_reg.cursor_col <= 7'(cur_col_reg);
            result_reg.cursor_row <= 5'(cur_row_reg);
            result_reg.scrolled   <= scroll_reg;
            if (item_reg.command == CMD_READ && read_ok)
            begin
                result_reg.cell_char  <= rd_data_reg[7:0];
                result_reg.cell_color <= rd_data_reg[15:8];
            end
            else
            begin
                result_reg.cell_char  <= '0;
                result_reg.cell_color <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            top_reg      <= '0;
            addr_reg     <= '0;
            fill_cnt_reg <= '0;
            scroll_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            top_reg      <= top_next;
            addr_reg     <= addr_next;
            fill_cnt_reg <= fill_cnt_next;
            scroll_reg   <= scroll_next;
            done_reg     <= ctrl.finish;
        end
    end

    always_comb
    begin
        status.command = item_reg.command;
        case (item_reg.char_code)
            CODE_NEWLINE:   status.kind = KIND_NEWLINE;
            CODE_RETURN:    status.kind = KIND_RETURN;
            CODE_TAB:       status.kind = KIND_TAB;
            CODE_BACKSPACE: status.kind = KIND_BACK;
            default:        status.kind = KIND_PRINT;
        endcase
        status.col_zero   = (cur_col_reg == '0);
        status.row_over   = (cur_row_reg >= ROW_W'(ROWS));
        status.read_ok    = read_ok;
        status.fill_last  = (fill_cnt_reg == FILL_W'(COLUMNS - 1));
        status.clear_last = (addr_reg == ADDR_W'(CELL_COUNT - 1));
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tcw_ctrl.sv -----
//------------------------------------------------------------------------------
// Text console controller
// Sequences each command through the datapath: cell writes and reads,
// read-modify-write for backspace, cursor wrap, scroll row fill and full-screen clear.
//------------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output logic            busy,
    output dp_ctrl_t        ctrl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ctrl.load_item  = 1'b0;
        ctrl.cur_op     = CUR_HOLD;
        ctrl.adr_op     = ADR_HOLD;
        ctrl.mem_op     = MEM_NONE;
        ctrl.fill_clr   = 1'b0;
        ctrl.scroll_set = 1'b0;
        ctrl.finish     = 1'b0;
        case (state_reg)
            // The cell store powers up unknown, so it is blanked before the first transfer.
            ST_INIT:
            begin
                ctrl.mem_op = MEM_WR_DEFAULT;
                ctrl.adr_op = ADR_INC;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.command)
                    CMD_PUT:
                    begin
                        case (status.kind)
                            KIND_NEWLINE:
                            begin
                                ctrl.cur_op = CUR_NEWLINE;
                                state_next  = ST_WRAP;
                            end
                            KIND_RETURN:
                            begin
                                ctrl.cur_op = CUR_RETURN;
                                state_next  = ST_WRAP;
                            end
                            KIND_TAB:
                            begin
                                ctrl.cur_op = CUR_TAB;
                                state_next  = ST_WRAP;
                            end
                            KIND_BACK:
                            begin
                                if (status.col_zero)
                                begin
                                    state_next = ST_WRAP;
                                end
                                else
                                begin
                                    ctrl.cur_op = CUR_BACK;
                                    state_next  = ST_ADDR;
                                end
                            end
                            default: state_next = ST_ADDR;
                        endcase
                    end
                    CMD_CLEAR:
                    begin
                        ctrl.adr_op = ADR_ZERO;
                        state_next  = ST_CLEAR;
                    end
                    CMD_READ: state_next = status.read_ok ? ST_ADDR : ST_DONE;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_ADDR:
            begin
                if (status.command == CMD_READ)
                begin
                    ctrl.adr_op = ADR_READ;
                    state_next  = ST_READ;
                end
                else
                begin
                    ctrl.adr_op = ADR_CURSOR;
                    state_next  = (status.kind == KIND_PRINT) ? ST_CHAR_WR : ST_READ;
                end
            end
            ST_READ:
            begin
                ctrl.mem_op = MEM_READ;
                state_next  = (status.command == CMD_READ) ? ST_DONE : ST_BACK_WR;
            end
            ST_BACK_WR:
            begin
                ctrl.mem_op = MEM_WR_BACK;
                state_next  = ST_WRAP;
            end
            ST_CHAR_WR:
            begin
                ctrl.mem_op = MEM_WR_CHAR;
                ctrl.cur_op = CUR_ADVANCE;
                state_next  = ST_WRAP;
            end
            ST_WRAP:
            begin
                ctrl.cur_op = CUR_WRAP;
                state_next  = ST_SCROLL;
            end
            ST_SCROLL:
            begin
                if (status.row_over)
                begin
                    ctrl.cur_op     = CUR_SCROLL;
                    ctrl.scroll_set = 1'b1;
                    state_next      = ST_FILL_ADDR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FILL_ADDR:
            begin
                ctrl.adr_op   = ADR_BOTTOM;
                ctrl.fill_clr = 1'b1;
                state_next    = ST_FILL;
            end
            ST_FILL:
            begin
                ctrl.mem_op = MEM_WR_BLANK;
                ctrl.adr_op = ADR_INC;
                if (status.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                ctrl.mem_op = MEM_WR_DEFAULT;
                ctrl.adr_op = ADR_INC;
                if (status.clear_last)
                begin
                    ctrl.cur_op = CUR_HOME;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                ctrl.finish = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/tcw_checker.sv -----
//------------------------------------------------------------------------------
// Text console port checker
// Watches the top-level ports for result strobe and cursor consistency.
//------------------------------------------------------------------------------
`default_nettype none

module tcw_checker
    import tcw_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    done,
    input wire result_t result
);

    // A transfer always starts work, so the block reports busy right after it.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a command transfer");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while the block is still busy");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (int'(result.cursor_col) < COLUMNS) && (int'(result.cursor_row) < ROWS))
        else $error("reported cursor lies outside the screen");

    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.scrolled) |-> (int'(result.cursor_row) == ROWS - 1))
        else $error("scroll reported with cursor off the last row");

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire

// ----- dv/text_console_char_writer_tb.sv -----
//------------------------------------------------------------------------------
// Text console character writer testbench
// Sends put, clear, read and unused commands through the start/busy handshake.
// A directed table comes first, then random runs of text, newlines, tabs,
// backspaces, reads, clears and noise. Each result is checked field by field
// against its typed table row, else an in-bench model of the 80 by 25 store and cursor.
//------------------------------------------------------------------------------
module text_console_char_writer_tb;
    import tcw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 450;
    localparam int         TAIL_CYCLES  = 20;

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item = '0;
    logic    busy;
    logic    done;
    result_t result;

    // Model of the console: cell store (attribute high, character low) and cursor.
    logic [15:0] screen_model [CELL_COUNT];
    int          cur_col;
    int          cur_row;

    result_t     predicted_results [$];
    result_t     oldest;
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    stim_row_t   directed_rows [24];

    text_console_char_writer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #10 clk = ~clk;

    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            screen_model[i] = {DEFAULT_ATTR, CODE_SPACE};
        end
        cur_col = 0;
        cur_row = 0;
    endfunction

    function automatic result_t apply_console_cmd(item_t it);
        result_t r;
        int      at;
        r = '0;
        case (it.command)
            CMD_PUT:
            begin
                if (it.char_code == CODE_NEWLINE)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else if (it.char_code == CODE_RETURN)
                begin
                    cur_col = 0;
                end
                else if (it.char_code == CODE_TAB)
                begin
                    cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
                end
                else if (it.char_code == CODE_BACKSPACE)
                begin
                    // The cell keeps its attribute; only the character is blanked.
                    if (cur_col > 0)
                    begin
                        cur_col--;
                        at = cur_row * COLUMNS + cur_col;
                        screen_model[at][7:0] = CODE_SPACE;
                    end
                end
                else
                begin
                    screen_model[cur_row * COLUMNS + cur_col] = {it.char_color, it.char_code};
                    cur_col++;
                end
                if (cur_col >= COLUMNS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS)
                begin
                    for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                    begin
                        screen_model[i] = screen_model[i + COLUMNS];
                    end
                    for (int i = 0; i < COLUMNS; i++)
                    begin
                        screen_model[(ROWS - 1) * COLUMNS + i] = {it.char_color, CODE_SPACE};
                    end
                    cur_row = ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                blank_screen();
            end
            CMD_READ:
            begin
                if (it.read_row < ROWS && it.read_col < COLUMNS)
                begin
                    at = it.read_row * COLUMNS + it.read_col;
                    r.cell_char  = screen_model[at][7:0];
                    r.cell_color = screen_model[at][15:8];
                end
            end
            default:
            begin
            end
        endcase
        r.cursor_col = 7'(cur_col);
        r.cursor_row = 5'(cur_row);
        return r;
    endfunction

    function automatic item_t random_fields();
        item_t it;
        it.command    = 2'($urandom_range(0, 3));
        it.char_code  = 8'($urandom_range(0, 255));
        it.char_color = 8'($urandom_range(0, 255));
        it.read_row   = 5'($urandom_range(0, 31));
        it.read_col   = 7'($urandom_range(0, 127));
        return it;
    endfunction

    // Sender pacing: bursts of back-to-back transfers separated by idle gaps.
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic transfer(input item_t it, input bit typed, input result_t want);
        result_t predicted;
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        predicted = apply_console_cmd(it);
        predicted_results.push_back(typed ? want : predicted);
        items_sent++;
        pace();
    endtask

    task automatic send_put(input logic [7:0] code);
        item_t it;
        it = random_fields();
        it.command   = CMD_PUT;
        it.char_code = code;
        transfer(it, 1'b0, '0);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing, actual 0x%h",
                         $time, result);
                mismatch_count++;
            end
            else
            begin
                oldest = predicted_results.pop_front();
                check_field("cursor_col", oldest.cursor_col, result.cursor_col);
                check_field("cursor_row", oldest.cursor_row, result.cursor_row);
                check_field("cell_char", oldest.cell_char, result.cell_char);
                check_field("cell_color", oldest.cell_color, result.cell_color);
                check_field("scrolled", oldest.scrolled, result.scrolled);
            end
        end
    end

    initial
    begin
        item_t it;
        int    seg;
        int    run;
        int    pick;

        directed_rows = '{
            '{'{CMD_READ,   8'h00, 8'h00, 5'd0,  7'd0},   1'b1, '{7'd0, 5'd0, 8'h20, 8'h07, 1'b0}},
            '{'{CMD_READ,   8'h00, 8'h00, 5'd24, 7'd79},  1'b1, '{7'd0, 5'd0, 8'h20, 8'h07, 1'b0}},
            '{'{CMD_READ,   8'h00, 8'h00, 5'd25, 7'd0},   1'b1, '{7'd0, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{'{CMD_READ,   8'h00, 8'h00, 5'd0,  7'd80},  1'b1, '{7'd0, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{'{CMD_READ,   8'hFF, 8'hFF, 5'd31, 7'd127}, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{'{CMD_UNUSED, 8'hFF, 8'hFF, 5'd31, 7'd127}, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{'{CMD_PUT,    8'h41, 8'h1E, 5'd0,  7'd0},   1'b0, '0},
            '{'{CMD_PUT,    8'h00, 8'h00, 5'd0,  7'd0},   1'b0, '0},
            '{'{CMD_PUT,    8'hFF, 8'hFF, 5'd0,  7'd0},   1'b0, '0},
            '{'{CMD_PUT,    CODE_BACKSPACE, 8'hAA, 5'd0, 7'd0}, 1'b0, '0},
            '{'{CMD_READ,   8'h00, 8'h00, 5'd0,  7'd2},   1'b0, '0},
            '{'{CMD_READ,   8'h00, 8'h00, 5'd0,  7'd1},   1'b0, '0},
            '{'{CMD_PUT,    CODE_TAB, 8'h00, 5'd0, 7'd0}, 1'b0, '0},
            '{'{CMD_PUT,    CODE_RETURN, 8'h00, 5'd0, 7'd0}, 1'b0, '0},
            '{'{CMD_PUT,    CODE_BACKSPACE, 8'h00, 5'd0, 7'd0}, 1'b0, '0},
            '{'{CMD_PUT,    CODE_NEWLINE, 8'h00, 5'd0, 7'd0}, 1'b0, '0},
            '{'{CMD_PUT,    8'h7A, 8'h4F, 5'd0,  7'd0},   1'b0, '0},
            '{'{CMD_READ,   8'h00, 8'h00, 5'd1,  7'd0},   1'b0, '0},
            '{'{CMD_CLEAR,  8'h00, 8'h00, 5'd0,  7'd0},   1'b1, '{7'd0, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{'{CMD_READ,   8'h00, 8'h00, 5'd0,  7'd0},   1'b1, '{7'd0, 5'd0, 8'h20, 8'h07, 1'b0}},
            '{'{CMD_READ,   8'h00, 8'h00, 5'd1,  7'd0},   1'b1, '{7'd0, 5'd0, 8'h20, 8'h07, 1'b0}},
            '{'{CMD_PUT,    8'h7E, 8'h00, 5'd0,  7'd0},   1'b0, '0},
            '{'{CMD_PUT,    8'h51, 8'h80, 5'd31, 7'd127}, 1'b0, '0},
            '{'{CMD_READ,   8'h00, 8'h00, 5'd0,  7'd0},   1'b0, '0}
        };

        blank_screen();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            transfer(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random runs: mostly well-formed text and cursor motion so that wraps,
        // tab overshoot and scrolling are reached, with some raw noise.
        while (items_sent < $size(directed_rows) + RANDOM_ITEMS)
        begin
            seg = $urandom_range(0, 99);
            if (seg < 40)
            begin
                run = $urandom_range(1, 90);
                repeat (run)
                begin
                    pick = $urandom_range(0, 19);
                    case (pick)
                        0: send_put(CODE_RETURN);
                        1: send_put(CODE_TAB);
                        2: send_put(CODE_BACKSPACE);
                        3: send_put(CODE_NEWLINE);
                        default: send_put(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            else if (seg < 55)
            begin
                run = $urandom_range(1, 30);
                repeat (run) send_put(CODE_NEWLINE);
            end
            else if (seg < 65)
            begin
                run = $urandom_range(1, 12);
                repeat (run) send_put(CODE_TAB);
            end
            else if (seg < 85)
            begin
                run = $urandom_range(1, 8);
                repeat (run)
                begin
                    it = random_fields();
                    it.command = CMD_READ;
                    pick = $urandom_range(0, 7);
                    if (pick < 4)
                    begin
                        it.read_row = 5'(cur_row);
                        it.read_col = 7'($urandom_range(0, COLUMNS - 1));
                    end
                    else if (pick < 7)
                    begin
                        it.read_row = 5'($urandom_range(0, ROWS - 1));
                        it.read_col = 7'($urandom_range(0, COLUMNS - 1));
                    end
                    transfer(it, 1'b0, '0);
                end
            end
            else if (seg < 95)
            begin
                run = $urandom_range(1, 10);
                repeat (run) send_put(CODE_BACKSPACE);
            end
            else if (seg < 97)
            begin
                it = random_fields();
                it.command = CMD_CLEAR;
                transfer(it, 1'b0, '0);
            end
            else
            begin
                run = $urandom_range(1, 6);
                repeat (run) transfer(random_fields(), 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (predicted_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("text_console_char_writer: match");
        end
        else
        begin
            $display("text_console_char_writer: mismatch");
        end
        $finish;
    end

    // Worst case is every item a full clear with the longest idle gap before it.
    initial
    begin
        #80_000_000;
        $display("text_console_char_writer: mismatch");
        $finish;
    end

endmodule
